// ===== sv/smr_pkg.sv =====
// Shared constants, register indexes and sequencer states for the stereo sample mixer voice.
// No dependencies; smr_mul and the top level import this package.
`timescale 1ns / 1ps

package smr_pkg;

  // Frame store depth; must be a power of two so that position wraps at the top bit.
  localparam int SAMPLE_FRAMES = 4096;
  localparam int INTERP_BITS   = 16;

  localparam int ADDR_W  = $clog2(SAMPLE_FRAMES);
  localparam int FRAC_W  = 32;
  localparam int POS_W   = ADDR_W + FRAC_W;
  localparam int CFG_W   = 44;
  localparam int VOL_W   = 32;
  localparam int ACC_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int FRAME_W = 2 * BYTE_W;
  localparam int SAMP_W  = BYTE_W + 1;
  localparam int SUM_W   = BYTE_W + 2;
  localparam int MUL_B_W = (INTERP_BITS + 1 > SUM_W) ? INTERP_BITS + 1 : SUM_W;
  localparam int PROD_W  = VOL_W + MUL_B_W;
  localparam int IN_W    = 96;
  localparam int OUT_W   = 64;
  localparam int CIDX_W  = 3;

  localparam logic [CFG_W-1:0] STEP_RESET = CFG_W'(64'h1_0000_0000);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MIX  = 1'b1;

  localparam logic [CIDX_W-1:0] REG_STEP        = 3'd0;
  localparam logic [CIDX_W-1:0] REG_START_POS   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_LVOL_START  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_LRAMP       = 3'd3;
  localparam logic [CIDX_W-1:0] REG_RVOL_START  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_RRAMP       = 3'd5;
  localparam logic [CIDX_W-1:0] REG_MONO_OUT    = 3'd6;
  localparam logic [CIDX_W-1:0] REG_INTERPOLATE = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_CAPB,
    S_IL,
    S_ILW,
    S_IR,
    S_IRW,
    S_ML,
    S_MLW,
    S_MR,
    S_MRW,
    S_DONE
  } state_t;

endpackage

// ===== sv/smr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the frame store.
`timescale 1ns / 1ps

module smr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/smr_mul.sv =====
// Shared signed multiplier with a registered product, used for every product of a mix.
// Depends on smr_pkg for operand widths.
`timescale 1ns / 1ps

module smr_mul
  import smr_pkg::*;
(
  input  logic                      clk,
  input  logic signed [VOL_W-1:0]   a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a * b);
  end

endmodule

// ===== sv/stereo_sample_mixer_ramp_top.sv =====
// Top level of one stereo sample mixer voice: sequencer, datapath, frame store and multiplier.
// Depends on smr_pkg, smr_ram and smr_mul.
`timescale 1ns / 1ps

// A load transaction (tuser = 0) writes one stereo frame into the 4096-entry frame store, and
// loads stream at one per cycle while no mix is in progress. A mix transaction (tuser = 1) holds
// the block after acceptance until s_tready returns: two reads through the single read port of
// the frame store, then one product at a time on the shared multiplier (two for interpolation,
// one for mono or two for stereo), each followed by a write-back step, and a done step that
// moves the result into the output register. So no new transaction is taken until a mix is
// through. The output register lets the block take the next transaction while a result still
// waits on m_tready; the last step of a mix stalls for as long as the previous result is still
// waiting. Position wraps modulo the store and accumulators wrap at 32 bits. Configuration
// writes land at once and are meant to be made while the block is idle.

module stereo_sample_mixer_ramp_top
  import smr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // load_address[11:0], load_left[19:12], load_right[27:20], restart[28],
  // acc_left_in[60:29], acc_right_in[92:61], zero[95:93]
  input  logic [IN_W-1:0]   s_tdata,
  // cmd[0]
  input  logic [0:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // acc_left_out[31:0], acc_right_out[63:32]
  output logic [OUT_W-1:0]  m_tdata,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // Input fields
  logic [11:0]             load_address;
  logic [FRAME_W-1:0]      load_frame;
  logic                    restart;
  logic [ACC_W-1:0]        acc_left_in;
  logic [ACC_W-1:0]        acc_right_in;

  assign load_address = s_tdata[11:0];
  assign load_frame   = s_tdata[27:12];
  assign restart      = s_tdata[28];
  assign acc_left_in  = s_tdata[60:29];
  assign acc_right_in = s_tdata[92:61];

  // Configuration registers
  logic signed [CFG_W-1:0] step;
  logic [CFG_W-1:0]        start_position;
  logic signed [VOL_W-1:0] left_volume_start;
  logic signed [VOL_W-1:0] left_ramp;
  logic signed [VOL_W-1:0] right_volume_start;
  logic signed [VOL_W-1:0] right_ramp;
  logic                    mono_out;
  logic                    interpolate;

  always_ff @(posedge clk) begin
    if (rst) begin
      step               <= STEP_RESET;
      start_position     <= '0;
      left_volume_start  <= '0;
      left_ramp          <= '0;
      right_volume_start <= '0;
      right_ramp         <= '0;
      mono_out           <= 1'b0;
      interpolate        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP:        step               <= cfg_data;
        REG_START_POS:   start_position     <= cfg_data;
        REG_LVOL_START:  left_volume_start  <= cfg_data[VOL_W-1:0];
        REG_LRAMP:       left_ramp          <= cfg_data[VOL_W-1:0];
        REG_RVOL_START:  right_volume_start <= cfg_data[VOL_W-1:0];
        REG_RRAMP:       right_ramp         <= cfg_data[VOL_W-1:0];
        REG_MONO_OUT:    mono_out           <= cfg_data[0];
        REG_INTERPOLATE: interpolate        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer
  state_t state;
  state_t state_next;
  logic   out_free;
  logic   out_load;
  logic   take;
  logic   mix_take;
  logic   load_take;

  assign s_tready  = (state == S_IDLE);
  assign take      = s_tvalid && s_tready;
  assign mix_take  = take && (s_tuser[0] == CMD_MIX);
  assign load_take = take && (s_tuser[0] == CMD_LOAD);
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = (state == S_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (mix_take) state_next = S_RDA;
      S_RDA:   state_next = S_RDB;
      S_RDB:   state_next = S_CAPB;
      S_CAPB:  state_next = interpolate ? S_IL : S_ML;
      S_IL:    state_next = S_ILW;
      S_ILW:   state_next = S_IR;
      S_IR:    state_next = S_IRW;
      S_IRW:   state_next = S_ML;
      S_ML:    state_next = S_MLW;
      S_MLW:   state_next = mono_out ? S_DONE : S_MR;
      S_MR:    state_next = S_MRW;
      S_MRW:   state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Voice state
  logic [POS_W-1:0]        position;
  logic signed [VOL_W-1:0] left_volume;
  logic signed [VOL_W-1:0] right_volume;
  logic [POS_W-1:0]        pos_cur;
  logic signed [VOL_W-1:0] lvol_base;
  logic signed [VOL_W-1:0] rvol_base;

  always_comb begin
    pos_cur   = restart ? POS_W'(start_position) : position;
    lvol_base = restart ? left_volume_start : left_volume;
    rvol_base = restart ? right_volume_start : right_volume;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      left_volume  <= '0;
      right_volume <= '0;
    end else if (mix_take) begin
      position     <= pos_cur + POS_W'(step);
      left_volume  <= lvol_base + left_ramp;
      right_volume <= mono_out ? rvol_base : rvol_base + right_ramp;
    end
  end

  // Frame store
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [FRAME_W-1:0] ram_rdata;
  logic [ADDR_W-1:0]  idx;
  logic [INTERP_BITS-1:0] frac;

  // Drop loads beyond the store.
  assign ram_we    = load_take && (load_address < SAMPLE_FRAMES);
  assign ram_waddr = ADDR_W'(load_address);
  assign ram_raddr = (state == S_RDA) ? idx : idx + 1'b1;

  smr_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (SAMPLE_FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (load_frame),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Datapath
  logic signed [ACC_W-1:0]   acc_l;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [BYTE_W-1:0]  a_l;
  logic signed [BYTE_W-1:0]  a_r;
  logic signed [BYTE_W-1:0]  b_l;
  logic signed [BYTE_W-1:0]  b_r;
  logic signed [SAMP_W-1:0]  samp_l;
  logic signed [SAMP_W-1:0]  samp_r;
  logic signed [SAMP_W-1:0]  diff_l;
  logic signed [SAMP_W-1:0]  diff_r;
  logic signed [SUM_W-1:0]   mono_sum;
  logic signed [SAMP_W-1:0]  interp_q;
  logic [PROD_W-1:0]         mono_adj;
  logic signed [VOL_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]          out_l;
  logic [ACC_W-1:0]          out_r;
  logic                      out_valid;

  assign diff_l   = SAMP_W'(b_l) - SAMP_W'(a_l);
  assign diff_r   = SAMP_W'(b_r) - SAMP_W'(a_r);
  assign mono_sum = SUM_W'(samp_l) + SUM_W'(samp_r);
  // Arithmetic shift floors the interpolation step.
  assign interp_q = SAMP_W'(prod >>> INTERP_BITS);
  // Bias negative products by one so the halving truncates toward zero.
  assign mono_adj = prod + PROD_W'(prod[PROD_W-1]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_IL: begin
        mul_a = VOL_W'(diff_l);
        mul_b = MUL_B_W'(frac);
      end
      S_IR: begin
        mul_a = VOL_W'(diff_r);
        mul_b = MUL_B_W'(frac);
      end
      S_ML: begin
        mul_a = left_volume;
        mul_b = mono_out ? MUL_B_W'(mono_sum) : MUL_B_W'(samp_l);
      end
      S_MR: begin
        mul_a = right_volume;
        mul_b = MUL_B_W'(samp_r);
      end
      default: ;
    endcase
  end

  smr_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (mix_take) begin
      idx   <= pos_cur[POS_W-1:FRAC_W];
      frac  <= pos_cur[FRAC_W-1 -: INTERP_BITS];
      acc_l <= acc_left_in;
      acc_r <= acc_right_in;
    end
    case (state)
      S_RDB: begin
        a_l <= ram_rdata[BYTE_W-1:0];
        a_r <= ram_rdata[FRAME_W-1:BYTE_W];
      end
      S_CAPB: begin
        b_l    <= ram_rdata[BYTE_W-1:0];
        b_r    <= ram_rdata[FRAME_W-1:BYTE_W];
        samp_l <= SAMP_W'(a_l);
        samp_r <= SAMP_W'(a_r);
      end
      S_ILW: samp_l <= SAMP_W'(a_l) + interp_q;
      S_IRW: samp_r <= SAMP_W'(a_r) + interp_q;
      S_MLW: begin
        if (mono_out) begin
          acc_l <= acc_l + mono_adj[ACC_W:1];
        end else begin
          acc_l <= acc_l + prod[ACC_W-1:0];
        end
      end
      S_MRW: acc_r <= acc_r + prod[ACC_W-1:0];
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_l <= acc_l;
      out_r <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_r, out_l};

  // Checks
  a_busy_after_mix: assert property (@(posedge clk) disable iff (rst)
    mix_take |=> !s_tready)
    else $error("block ready right after a mix transaction");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    load_take |=> !$rose(m_tvalid))
    else $error("result raised by a load transaction");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result raised outside the done step");

  a_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE) && (s_tuser[0] == CMD_LOAD))
    else $error("frame store written during a mix");

endmodule
